[rtl/core/tracked_target_selector_defines.svh]
// Assertion macros used by the tracked target selector RTL.
`ifndef TRACKED_TARGET_SELECTOR_DEFINES_SVH
`define TRACKED_TARGET_SELECTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TTS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/tts_pkg.sv]
// Types, widths and helper functions for the tracked target selector.
`timescale 1ns / 1ps
package tts_pkg;

  localparam int COORD_BITS = 12;
  localparam int CTR_BITS   = COORD_BITS + 1;
  localparam int AREA_BITS  = 2 * COORD_BITS;
  localparam int SQ_BITS    = 2 * CTR_BITS;
  localparam int SCORE_BITS = SQ_BITS + 1;
  localparam int RECT_BITS  = 4 * COORD_BITS;
  localparam int DATA_BITS  = ((RECT_BITS + 7) / 8) * 8;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [CTR_BITS-1:0]   ctr_t;
  typedef logic [AREA_BITS-1:0]  area_t;
  typedef logic [SQ_BITS-1:0]    sq_t;
  typedef logic [SCORE_BITS-1:0] score_t;

  // x sits in the lowest bits, h in the highest
  typedef struct packed {
    coord_t h;
    coord_t w;
    coord_t y;
    coord_t x;
  } rect_t;

  // One beat after the score stage
  typedef struct packed {
    logic  present;
    logic  last;
    rect_t rect;
    area_t area;
    sq_t   sq_x;
    sq_t   sq_y;
  } score_beat_t;

  // Center coordinate with the half size rounded down
  function automatic ctr_t center(coord_t pos, coord_t size);
    return ctr_t'(pos) + ctr_t'(size >> 1);
  endfunction

  function automatic ctr_t abs_diff(ctr_t a, ctr_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

[rtl/core/tts_score.sv]
// Score stage: area and squared center offsets of one rectangle, registered.
`timescale 1ns / 1ps
module tts_score import tts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s1_adv,
  input  rect_t       s1_rect,
  input  logic        s1_present,
  input  logic        s1_last,
  input  rect_t       track_rect,
  input  logic        s2_adv,
  output logic        s2_vld,
  output score_beat_t s2_beat
);

  logic        s2_vld_r;
  score_beat_t s2_beat_r;
  score_beat_t s2_beat_nxt;
  ctr_t        dx;
  ctr_t        dy;

  // center offsets against the current track
  always_comb begin
    dx = abs_diff(center(s1_rect.x, s1_rect.w), center(track_rect.x, track_rect.w));
    dy = abs_diff(center(s1_rect.y, s1_rect.h), center(track_rect.y, track_rect.h));
  end

  // products for both selection modes
  always_comb begin
    s2_beat_nxt.present = s1_present;
    s2_beat_nxt.last    = s1_last;
    s2_beat_nxt.rect    = s1_rect;
    s2_beat_nxt.area    = area_t'(s1_rect.w) * area_t'(s1_rect.h);
    s2_beat_nxt.sq_x    = sq_t'(dx) * sq_t'(dx);
    s2_beat_nxt.sq_y    = sq_t'(dy) * sq_t'(dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s1_adv) begin
      s2_vld_r <= 1'b1;
    end else if (s2_adv) begin
      s2_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_beat_r <= s2_beat_nxt;
    end
  end

  assign s2_vld  = s2_vld_r;
  assign s2_beat = s2_beat_r;

endmodule

[rtl/core/tts_select.sv]
// Select stage: running best of the frame, track state and result register.
`timescale 1ns / 1ps
module tts_select import tts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s2_vld,
  input  score_beat_t s2_beat,
  input  logic        out_tready,
  output logic        s2_adv,
  output rect_t       track_rect,
  output logic        track_known,
  output logic        out_vld,
  output rect_t       out_rect,
  output logic        out_known
);

  rect_t  best_rect_r,   best_rect_nxt;
  score_t best_score_r,  best_score_nxt;
  logic   best_held_r,   best_held_nxt;
  rect_t  track_rect_r,  track_rect_nxt;
  logic   track_known_r, track_known_nxt;
  logic   out_vld_r,     out_vld_nxt;
  rect_t  out_rect_r;
  logic   out_known_r;
  logic   out_free;
  logic   out_load;
  score_t score;
  logic   better;
  logic   take;

  assign out_free = !out_vld_r || out_tready;
  assign s2_adv   = s2_vld && (!s2_beat.last || out_free);
  assign out_load = s2_adv && s2_beat.last;

  // score for the current mode and compare against the running best
  always_comb begin
    if (track_known_r) begin
      score  = score_t'(s2_beat.sq_x) + score_t'(s2_beat.sq_y);
      better = score < best_score_r;
    end else begin
      score  = score_t'(s2_beat.area);
      better = score > best_score_r;
    end
    take = s2_beat.present && (!best_held_r || better);
  end

  // next state of best, track and result
  always_comb begin
    best_rect_nxt   = best_rect_r;
    best_score_nxt  = best_score_r;
    best_held_nxt   = best_held_r;
    track_rect_nxt  = track_rect_r;
    track_known_nxt = track_known_r;
    out_vld_nxt     = out_vld_r && !out_tready;
    if (s2_adv) begin
      if (take) begin
        best_rect_nxt  = s2_beat.rect;
        best_score_nxt = score;
        best_held_nxt  = 1'b1;
      end
      if (s2_beat.last) begin
        if (take || best_held_r) begin
          track_rect_nxt  = take ? s2_beat.rect : best_rect_r;
          track_known_nxt = 1'b1;
        end
        best_held_nxt  = 1'b0;
        best_score_nxt = '0;
        out_vld_nxt    = 1'b1;
      end
    end
  end

  // control and track state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_held_r   <= 1'b0;
      track_rect_r  <= '0;
      track_known_r <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      best_held_r   <= best_held_nxt;
      track_rect_r  <= track_rect_nxt;
      track_known_r <= track_known_nxt;
      out_vld_r     <= out_vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    best_rect_r  <= best_rect_nxt;
    best_score_r <= best_score_nxt;
    if (out_load) begin
      out_rect_r  <= track_rect_nxt;
      out_known_r <= track_known_nxt;
    end
  end

  assign track_rect  = track_rect_r;
  assign track_known = track_known_r;
  assign out_vld     = out_vld_r;
  assign out_rect    = out_rect_r;
  assign out_known   = out_known_r;

endmodule

[rtl/core/tracked_target_selector.sv]
// A frame-end beat's result reaches out_* through the input, score and result registers.
// Throughput: one beat per cycle unless out_tready stalls; after each frame-end beat the
// input register waits for it to leave select, since the next offsets need the updated track.
// Reset (rst_n low, synchronous): no track, empty frame, all stages and the result empty.
// A result beat is produced only for input beats with in_tlast high.
`timescale 1ns / 1ps
`include "tracked_target_selector_defines.svh"
module tracked_target_selector import tts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [DATA_BITS-1:0] in_tdata,  // box_x, box_y, box_w, box_h
  input  logic                 in_tuser,  // box_present
  input  logic                 in_tlast,  // frame_end
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [DATA_BITS-1:0] out_tdata, // track_x, track_y, track_w, track_h
  output logic                 out_tuser  // track_valid
);

  logic        s1_vld_r, s1_vld_nxt;
  rect_t       s1_rect_r;
  logic        s1_present_r;
  logic        s1_last_r;
  logic        s1_adv;
  logic        in_take;
  logic        s2_vld;
  score_beat_t s2_beat;
  logic        s2_adv;
  rect_t       track_rect;
  logic        track_known;
  rect_t       out_rect;

  // input register; it waits while a frame-end beat is still in the select stage
  assign s1_adv    = s1_vld_r && (!s2_vld || (s2_adv && !s2_beat.last));
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_take) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_rect_r    <= rect_t'(in_tdata[RECT_BITS-1:0]);
      s1_present_r <= in_tuser;
      s1_last_r    <= in_tlast;
    end
  end

  tts_score u_score (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_adv     (s1_adv),
    .s1_rect    (s1_rect_r),
    .s1_present (s1_present_r),
    .s1_last    (s1_last_r),
    .track_rect (track_rect),
    .s2_adv     (s2_adv),
    .s2_vld     (s2_vld),
    .s2_beat    (s2_beat)
  );

  tts_select u_select (
    .clk         (clk),
    .rst_n       (rst_n),
    .s2_vld      (s2_vld),
    .s2_beat     (s2_beat),
    .out_tready  (out_tready),
    .s2_adv      (s2_adv),
    .track_rect  (track_rect),
    .track_known (track_known),
    .out_vld     (out_tvalid),
    .out_rect    (out_rect),
    .out_known   (out_tuser)
  );

  assign out_tdata = DATA_BITS'(out_rect);

  // checks
  `TTS_ASSERT_NEXT(a_track_sticky, track_known, track_known, "track lost after being known")
  `TTS_ASSERT_SAME(a_no_track_zero, out_tvalid && !out_tuser, out_tdata == '0, "untracked result not zero")
  `TTS_ASSERT_SAME(a_out_from_end, $rose(out_tvalid), $past(s2_vld && s2_beat.last), "result without frame end")

endmodule
